// ===== rtl/core/xmld_pkg.sv =====
// xmld_pkg: shared types, constants and helpers for the xml message deframer
// no dependencies; imported by xml_message_deframer, its checker and its bench
package xmld_pkg;

   localparam int MAX_NAME_LENGTH_DEF = 64;

   localparam logic [7:0] CHAR_LT    = 8'h3C;  // '<'
   localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
   localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_NAME  = 2'd1,
      PH_MATCH = 2'd2
   } phase_type;

   function automatic logic is_name_char(input logic [7:0] c);
      logic upper, lower, digit;
      upper = (c >= 8'h41) && (c <= 8'h5A);
      lower = (c >= 8'h61) && (c <= 8'h7A);
      digit = (c >= 8'h30) && (c <= 8'h39);
      return upper || lower || digit || (c == 8'h5F);
   endfunction

endpackage

// ===== rtl/core/xml_message_deframer.sv =====
// xml_message_deframer: root element deframer for a stream of concatenated xml messages
// depends on xmld_pkg; name store is a local memory with a registered read port
//
// Usage:
//   req channel (req_valid/req_stall/req_data_byte) takes one character per beat.
//   rsp channel (rsp_valid/rsp_stall/rsp_*) returns one beat per request beat:
//   the character unchanged, message_end on the final '>' of the close tag
//   "</name>" matching the leading element, and name_overflow when the leading
//   name runs past MAX_NAME_LENGTH characters (the hunt for '<' then restarts).
//   An accepted request beat raises rsp_valid in the next cycle.
//   Throughput is one beat per cycle unless stalled: each byte is decided
//   combinationally from the phase register and one name character prefetched
//   from the name store, whose read address follows the next match position.
//   A single output register holds the result; req_stall is raised only while
//   that register is full and the receiver stalls, so a stalled result holds
//   and nothing is lost or repeated.
//   Reset (synchronous) returns to hunting for '<' and empties the output
//   register; the name store is not cleared and needs no clearing pass.
module xml_message_deframer #(
   parameter int MAX_NAME_LENGTH = xmld_pkg::MAX_NAME_LENGTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_message_end,
   output logic       rsp_name_overflow
);
   import xmld_pkg::*;

   localparam int LEN_W  = $clog2(MAX_NAME_LENGTH + 1);
   localparam int POS_W  = $clog2(MAX_NAME_LENGTH + 3);
   localparam int ADDR_W = (MAX_NAME_LENGTH > 1) ? $clog2(MAX_NAME_LENGTH) : 1;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_NAME_LENGTH);
   localparam logic [POS_W-1:0] POS_TWO = POS_W'(2);

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       name_mem [MAX_NAME_LENGTH];
   logic [7:0]       name_rd_ff;
   logic             wr_en;
   logic [POS_W-1:0] rd_idx;

   logic             rsp_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             message_end_ff, name_overflow_ff;

   logic             accept;
   logic             is_name;
   logic [POS_W-1:0] m_pos, m_pos_next, len_ext;
   logic [7:0]       expected;
   logic             m_hit, m_done;
   logic             end_in, ovf_in;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign is_name   = is_name_char(req_data_byte);
   assign len_ext   = POS_W'(len_ff);

   // close tag matcher, starting position depends on phase
   always_comb begin
      m_pos = (phase_ff == PH_MATCH) ? pos_ff : '0;
      if (m_pos == '0) begin
         expected = CHAR_LT;
      end else if (m_pos == POS_W'(1)) begin
         expected = CHAR_SLASH;
      end else if ((m_pos - POS_TWO) < len_ext) begin
         expected = name_rd_ff;
      end else begin
         expected = CHAR_GT;
      end
      m_hit  = (req_data_byte == expected);
      m_done = m_hit && (m_pos == (len_ext + POS_TWO));
      if (m_hit) begin
         m_pos_next = m_done ? '0 : m_pos + POS_W'(1);
      end else begin
         m_pos_next = (req_data_byte == CHAR_LT) ? POS_W'(1) : '0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      wr_en    = 1'b0;
      end_in   = 1'b0;
      ovf_in   = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_NAME: begin
               if (is_name) begin
                  if (len_ff < MAX_LEN) begin
                     wr_en  = 1'b1;
                     len_in = len_ff + LEN_W'(1);
                  end else begin
                     ovf_in   = 1'b1;
                     len_in   = '0;
                     phase_in = PH_HUNT;
                  end
               end else if (len_ff == '0) begin
                  phase_in = (req_data_byte == CHAR_LT) ? PH_NAME : PH_HUNT;
               end else begin
                  pos_in   = m_pos_next;
                  end_in   = m_done;
                  phase_in = m_done ? PH_HUNT : PH_MATCH;
               end
            end
            PH_MATCH: begin
               pos_in   = m_pos_next;
               end_in   = m_done;
               phase_in = m_done ? PH_HUNT : PH_MATCH;
            end
            default: begin
               phase_in = PH_HUNT;
               if (req_data_byte == CHAR_LT) begin
                  phase_in = PH_NAME;
                  len_in   = '0;
               end
            end
         endcase
      end
   end

   // prefetch the name character for the next match position
   assign rd_idx = pos_in - POS_TWO;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[len_ff[ADDR_W-1:0]] <= req_data_byte;
      end
      name_rd_ff <= name_mem[rd_idx[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         len_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_byte_ff      <= req_data_byte;
         message_end_ff   <= end_in;
         name_overflow_ff <= ovf_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_message_end   = message_end_ff;
   assign rsp_name_overflow = name_overflow_ff;

endmodule

// ===== rtl/core/xmld_checker.sv =====
// xmld_checker: port level assertions for xml_message_deframer, bound into xml_message_deframer
// depends on xmld_pkg
module xmld_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_data_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_message_end,
   input logic       rsp_name_overflow
);
   import xmld_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_message_end) && $stable(rsp_name_overflow))
      else $error("stalled result beat changed");

   // every accepted request beat shows up on the next cycle with its byte
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid && rsp_out_byte == $past(req_data_byte))
      else $error("accepted beat not presented on rsp");

   a_end_on_gt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_out_byte == CHAR_GT)
      else $error("message end on a byte other than '>'");

   a_ovf_on_name: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_name_overflow |-> is_name_char(rsp_out_byte) && !rsp_message_end)
      else $error("overflow flagged on a non-name byte");

endmodule

bind xml_message_deframer xmld_checker u_xmld_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_data_byte     (req_data_byte),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_message_end   (rsp_message_end),
   .rsp_name_overflow (rsp_name_overflow)
);

// ===== tb/sv/xml_message_deframer_tb.sv =====
// xml_message_deframer_tb: self-checking bench for the xml message deframer
// drives a directed table then random message streams, predicts every rsp beat
// depends on xmld_pkg and rtl/core/xml_message_deframer.sv
module xml_message_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import xmld_pkg::*;

   localparam int NAME_MAX = MAX_NAME_LENGTH_DEF;
   localparam int CYCLE_LIMIT = 150000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       msg_end;
      logic       overflow;
   } deframe_beat_type;

   typedef struct {
      logic [7:0] data;
      bit         typed;
      bit         msg_end;
      bit         overflow;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_message_end;
   logic       rsp_name_overflow;

   xml_message_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_message_end  (rsp_message_end),
      .rsp_name_overflow(rsp_name_overflow)
   );

   // deframer shadow state
   phase_type   scan_phase = PH_HUNT;
   logic [7:0]  tag_chars [NAME_MAX];
   int unsigned tag_len = 0;
   int unsigned close_pos = 0;

   deframe_beat_type pending_beats[$];
   int unsigned   beats_sent = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_stall_pct = 0;

   // leading element cases: empty names, '<' ending a name, '<' mismatch, byte extremes
   stim_row_type directed_rows [0:26] = '{
      '{CHAR_LT,    1'b1, 1'b0, 1'b0},
      '{CHAR_GT,    1'b1, 1'b0, 1'b0},
      '{CHAR_LT,    1'b0, 1'b0, 1'b0},
      '{CHAR_LT,    1'b0, 1'b0, 1'b0},
      '{"b",        1'b0, 1'b0, 1'b0},
      '{CHAR_LT,    1'b0, 1'b0, 1'b0},
      '{CHAR_SLASH, 1'b0, 1'b0, 1'b0},
      '{"b",        1'b0, 1'b0, 1'b0},
      '{CHAR_GT,    1'b1, 1'b1, 1'b0},
      '{CHAR_LT,    1'b0, 1'b0, 1'b0},
      '{"z",        1'b0, 1'b0, 1'b0},
      '{"_",        1'b0, 1'b0, 1'b0},
      '{8'h00,      1'b1, 1'b0, 1'b0},
      '{CHAR_LT,    1'b0, 1'b0, 1'b0},
      '{CHAR_SLASH, 1'b0, 1'b0, 1'b0},
      '{"z",        1'b0, 1'b0, 1'b0},
      '{"_",        1'b0, 1'b0, 1'b0},
      '{CHAR_GT,    1'b1, 1'b1, 1'b0},
      '{CHAR_LT,    1'b0, 1'b0, 1'b0},
      '{"A",        1'b0, 1'b0, 1'b0},
      '{CHAR_GT,    1'b0, 1'b0, 1'b0},
      '{8'hFF,      1'b1, 1'b0, 1'b0},
      '{CHAR_LT,    1'b0, 1'b0, 1'b0},
      '{CHAR_LT,    1'b0, 1'b0, 1'b0},
      '{CHAR_SLASH, 1'b0, 1'b0, 1'b0},
      '{"A",        1'b0, 1'b0, 1'b0},
      '{CHAR_GT,    1'b1, 1'b1, 1'b0}
   };

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   function automatic bit name_char_ok(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h5F};
   endfunction

   // character expected at position p of "</name>"
   function automatic logic [7:0] close_tag_at(input int unsigned p);
      if (p == 0) return CHAR_LT;
      if (p == 1) return CHAR_SLASH;
      if (p - 2 < tag_len) return tag_chars[p - 2];
      return CHAR_GT;
   endfunction

   function automatic bit advance_close(input logic [7:0] c);
      if (c == close_tag_at(close_pos)) begin
         close_pos++;
         if (close_pos >= tag_len + 3) begin
            close_pos = 0;
            return 1'b1;
         end
      end else begin
         // only the tag opener can restart a partial match mid-way
         close_pos = (c == CHAR_LT) ? 1 : 0;
      end
      return 1'b0;
   endfunction

   function automatic deframe_beat_type deframe_byte(input logic [7:0] c);
      deframe_beat_type r;
      r.out_byte = c;
      r.msg_end = 1'b0;
      r.overflow = 1'b0;
      case (scan_phase)
         PH_NAME: begin
            if (name_char_ok(c)) begin
               if (tag_len < NAME_MAX) begin
                  tag_chars[tag_len] = c;
                  tag_len++;
               end else begin
                  r.overflow = 1'b1;
                  tag_len = 0;
                  scan_phase = PH_HUNT;
               end
            end else if (tag_len == 0) begin
               scan_phase = (c == CHAR_LT) ? PH_NAME : PH_HUNT;
            end else begin
               // the byte closing the name is already a close tag candidate
               scan_phase = PH_MATCH;
               close_pos = 0;
               if (advance_close(c)) begin
                  r.msg_end = 1'b1;
                  scan_phase = PH_HUNT;
               end
            end
         end
         PH_MATCH: begin
            if (advance_close(c)) begin
               r.msg_end = 1'b1;
               scan_phase = PH_HUNT;
            end
         end
         default: begin
            scan_phase = PH_HUNT;
            if (c == CHAR_LT) begin
               scan_phase = PH_NAME;
               tag_len = 0;
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch %s: got 0x%0h, expected 0x%0h (cycle %0d)",
               what, got, want, cycle_count);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      deframe_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            report_mismatch("unexpected beat", 32'(rsp_out_byte), 0);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_out_byte != want.out_byte)
               report_mismatch("out_byte", 32'(rsp_out_byte), 32'(want.out_byte));
            if (rsp_message_end != want.msg_end)
               report_mismatch("message_end", 32'(rsp_message_end), 32'(want.msg_end));
            if (rsp_name_overflow != want.overflow)
               report_mismatch("name_overflow", 32'(rsp_name_overflow),
                               32'(want.overflow));
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input bit t_end = 1'b0, input bit t_ovf = 1'b0);
      deframe_beat_type got;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      got = deframe_byte(b);
      if (typed) begin
         got.msg_end = t_end;
         got.overflow = t_ovf;
      end
      pending_beats.push_back(got);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain_beats();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] random_name_char();
      int unsigned k;
      k = $urandom_range(0, 62);
      if (k < 10) return 8'(8'h30 + k);
      if (k < 36) return 8'(8'h41 + k - 10);
      if (k < 62) return 8'(8'h61 + k - 36);
      return "_";
   endfunction

   function automatic logic [7:0] random_name_end();
      case ($urandom_range(0, 3))
         0: return CHAR_GT;
         1: return " ";
         2: return CHAR_SLASH;
         default: return CHAR_LT;
      endcase
   endfunction

   // close tag for the given name, one name character corrupted unless bad_at < 0
   task automatic push_close(input logic [7:0] name_q[$], input int bad_at);
      push_byte(CHAR_LT);
      push_byte(CHAR_SLASH);
      foreach (name_q[i]) push_byte((i == bad_at) ? (name_q[i] ^ 8'h01) : name_q[i]);
      push_byte(CHAR_GT);
   endtask

   // bring the block back to hunting so the next message starts clean
   task automatic resync();
      logic [7:0] held[$];
      if (scan_phase == PH_NAME) push_byte((tag_len == 0) ? " " : CHAR_GT);
      if (scan_phase == PH_MATCH) begin
         for (int unsigned i = 0; i < tag_len; i++) held.push_back(tag_chars[i]);
         push_close(held, -1);
      end
   endtask

   task automatic send_random_until(input int unsigned upto);
      int unsigned msg_idx;
      int unsigned roll;
      int unsigned name_len;
      int unsigned cut;
      logic [7:0]  name_q[$];
      msg_idx = 0;
      while (beats_sent < upto) begin
         roll = $urandom_range(0, 99);
         if (msg_idx == 0) roll = 97;
         name_q.delete();
         if (msg_idx == 1) name_len = NAME_MAX;
         else if ($urandom_range(0, 29) == 0) name_len = $urandom_range(NAME_MAX - 4, NAME_MAX);
         else name_len = $urandom_range(1, 6);
         repeat (name_len) name_q.push_back(random_name_char());
         if (msg_idx == 1) roll = 0;
         resync();
         if (roll < 75) begin
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
            resync();
            push_byte(CHAR_LT);
            foreach (name_q[i]) push_byte(name_q[i]);
            push_byte(random_name_end());
            repeat ($urandom_range(0, 8)) push_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0) begin
               // a close tag that breaks off part way
               cut = $urandom_range(0, name_q.size() - 1);
               push_byte(CHAR_LT);
               push_byte(CHAR_SLASH);
               for (int unsigned i = 0; i < cut; i++) push_byte(name_q[i]);
               push_byte(" ");
            end
            push_close(name_q, -1);
         end else if (roll < 88) begin
            push_byte(CHAR_LT);
            foreach (name_q[i]) push_byte(name_q[i]);
            push_byte(CHAR_GT);
            push_close(name_q, $urandom_range(0, name_q.size() - 1));
            if ($urandom_range(0, 1) == 0) push_close(name_q, -1);
         end else if (roll < 95) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
         end else begin
            push_byte(CHAR_LT);
            repeat (NAME_MAX + 1 + $urandom_range(0, 2)) push_byte(random_name_char());
         end
         msg_idx++;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      recv_stall_pct = 83;
      foreach (directed_rows[i])
         push_byte(directed_rows[i].data, directed_rows[i].typed,
                   directed_rows[i].msg_end, directed_rows[i].overflow);
      send_random_until(160);
      drain_beats();

      send_idle_pct = 83;
      recv_stall_pct = 16;
      send_random_until(310);
      drain_beats();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_random_until(460);
      drain_beats();

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/xmld_pkg.sv
rtl/core/xml_message_deframer.sv
rtl/core/xmld_checker.sv
tb/sv/xml_message_deframer_tb.sv
